// ----- hdl/rank_then_binary_radix_sort_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the radix sort block
// Implication checks with a shared clock and reset; one use per line.
// ----------------------------------------------------------------------------
`ifndef RANK_THEN_BINARY_RADIX_SORT_ASSERT_SVH
`define RANK_THEN_BINARY_RADIX_SORT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTBRS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTBRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/rtbrs_pkg.sv -----
// ----------------------------------------------------------------------------
// rtbrs_pkg
// Sizes, widths and shared types of the rank-then-radix sort block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtbrs_pkg;

   // List and sort limits.
   localparam int MAX_ITEMS  = 64;
   localparam int PASS_LIMIT = 32;
   localparam int MOVE_CAP   = 8192;

   // Derived widths.
   localparam int DATA_W = 32;
   localparam int BIT_W  = $clog2(DATA_W);
   localparam int IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int PASS_W = $clog2(PASS_LIMIT + 1);
   localparam int MOVE_W = 14;

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_FIELD_W = DATA_W + MOVE_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   // Write port of one list bank.
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [DATA_W-1:0] data;
   } ram_wr_type;

endpackage

// ----- hdl/rank_then_binary_radix_sort.sv -----
// ----------------------------------------------------------------------------
// rank_then_binary_radix_sort
// Collects a list of signed words, ranks it when a value is negative, then
// sorts it with binary LSD radix passes and streams it back with move count.
// ----------------------------------------------------------------------------
//  channel | direction | tdata (low bit up)             | tlast
//  req     | in        | value[31:0]                    | last element of list
//  rsp     | out       | value[31:0], moves[45:32], pad | last element of run
//
// Request beats are taken one per cycle while req_tready is high. After the
// last beat the block is busy (req_tready low): it ranks the list if a value
// is negative, then runs order checks and radix passes, each walking the list
// bank through its one read port one element per cycle.
// Each response beat is read from the bank, registered, then held through any stall on rsp_tready.
// Reset is synchronous and empties the list; the next list may start once the
// beat marked last has been taken on rsp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "rank_then_binary_radix_sort_assert.svh"

module rank_then_binary_radix_sort (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [rtbrs_pkg::REQ_TDATA_W-1:0]     req_tdata,  // value[31:0]
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [rtbrs_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // value, moves, zero pad
   output logic                                  rsp_tlast
);

   localparam int DATA_W = rtbrs_pkg::DATA_W;
   localparam int IDX_W  = rtbrs_pkg::IDX_W;
   localparam int CNT_W  = rtbrs_pkg::CNT_W;
   localparam int PASS_W = rtbrs_pkg::PASS_W;
   localparam int MOVE_W = rtbrs_pkg::MOVE_W;
   localparam int BIT_W  = rtbrs_pkg::BIT_W;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_RK_GET,
      ST_RK_LATCH,
      ST_RK_SCAN,
      ST_CHECK,
      ST_PASS_Z,
      ST_PASS_O,
      ST_EM_RD,
      ST_EM_LD,
      ST_EM_WAIT
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              neg_ff, neg_in;
   logic              bank_ff, bank_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   logic [MOVE_W-1:0] moves_ff, moves_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              pv_ff, pv_in;
   logic [IDX_W-1:0]  pidx_ff, pidx_in;
   logic [CNT_W-1:0]  rank_i_ff, rank_i_in;
   logic [IDX_W-1:0]  rank_cnt_ff, rank_cnt_in;
   logic [DATA_W-1:0] vi_ff, vi_in;
   logic [DATA_W-1:0] prev_ff, prev_in;
   logic              unsorted_ff, unsorted_in;
   logic [CNT_W-1:0]  wcnt_ff, wcnt_in;
   logic [CNT_W-1:0]  zcnt_ff, zcnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] out_value_ff, out_value_in;
   logic [MOVE_W-1:0] out_moves_ff, out_moves_in;
   logic              out_last_ff, out_last_in;

   rtbrs_pkg::ram_wr_type wr, wr0, wr1;
   logic              wr_bank;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd0, rd1, rd_data;
   logic              sweep, issue, sweep_done, req_beat, stored;
   logic [MOVE_W:0]   moves_sum;
   logic [BIT_W-1:0]  bit_idx;

   // Two list banks; the current list lives in bank_ff.
   assign wr0 = '{en: wr.en && !wr_bank, addr: wr.addr, data: wr.data};
   assign wr1 = '{en: wr.en &&  wr_bank, addr: wr.addr, data: wr.data};

   rtbrs_ram u_bank0 (.clock(clock), .wr(wr0), .rd_addr(rd_addr), .rd_data(rd0));
   rtbrs_ram u_bank1 (.clock(clock), .wr(wr1), .rd_addr(rd_addr), .rd_data(rd1));

   assign rd_data = bank_ff ? rd1 : rd0;
   assign rd_addr = (state_ff == ST_RK_GET) ? rank_i_ff[IDX_W-1:0] : scan_ff[IDX_W-1:0];

   // Handshake and helper terms.
   assign req_tready = (state_ff == ST_LOAD);
   assign req_beat   = req_tvalid && req_tready;
   assign stored     = count_ff < CNT_W'(rtbrs_pkg::MAX_ITEMS);
   assign issue      = scan_ff < count_ff;
   assign sweep_done = !issue && !pv_ff;
   assign sweep      = state_ff inside {ST_RK_SCAN, ST_CHECK, ST_PASS_Z, ST_PASS_O};
   assign bit_idx    = BIT_W'(pass_ff);
   assign moves_sum  = (MOVE_W + 1)'(moves_ff) + (MOVE_W + 1)'(count_ff)
                     + (MOVE_W + 1)'(zcnt_ff);

   // Sequencer next-state and datapath.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      neg_in       = neg_ff;
      bank_in      = bank_ff;
      pass_in      = pass_ff;
      moves_in     = moves_ff;
      scan_in      = scan_ff;
      pv_in        = pv_ff;
      pidx_in      = pidx_ff;
      rank_i_in    = rank_i_ff;
      rank_cnt_in  = rank_cnt_ff;
      vi_in        = vi_ff;
      prev_in      = prev_ff;
      unsorted_in  = unsorted_ff;
      wcnt_in      = wcnt_ff;
      zcnt_in      = zcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      out_value_in = out_value_ff;
      out_moves_in = out_moves_ff;
      out_last_in  = out_last_ff;
      wr           = '0;
      wr_bank      = !bank_ff;

      // Walk the current bank one element per cycle; data returns in the next cycle.
      if (sweep) begin
         scan_in = issue ? CNT_W'(scan_ff + CNT_W'(1)) : scan_ff;
         pv_in   = issue;
         pidx_in = scan_ff[IDX_W-1:0];
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_beat) begin
               if (stored) begin
                  wr_bank  = bank_ff;
                  wr       = '{en: 1'b1, addr: count_ff[IDX_W-1:0],
                               data: req_tdata[DATA_W-1:0]};
                  count_in = CNT_W'(count_ff + CNT_W'(1));
                  neg_in   = neg_ff || req_tdata[DATA_W-1];
               end
               if (req_tlast) begin
                  scan_in     = '0;
                  pv_in       = 1'b0;
                  unsorted_in = 1'b0;
                  rank_i_in   = '0;
                  pass_in     = '0;
                  if (neg_ff || (stored && req_tdata[DATA_W-1])) begin
                     state_in = ST_RK_GET;
                  end else begin
                     state_in = ST_CHECK;
                  end
               end
            end
         end

         ST_RK_GET: begin
            state_in = ST_RK_LATCH;
         end

         // Hold the element being ranked and start counting smaller ones.
         ST_RK_LATCH: begin
            vi_in       = rd_data;
            rank_cnt_in = '0;
            scan_in     = '0;
            pv_in       = 1'b0;
            state_in    = ST_RK_SCAN;
         end

         ST_RK_SCAN: begin
            if (pv_ff) begin
               if (($signed(rd_data) < $signed(vi_ff)) ||
                   ((rd_data == vi_ff) && (pidx_ff < rank_i_ff[IDX_W-1:0]))) begin
                  rank_cnt_in = IDX_W'(rank_cnt_ff + IDX_W'(1));
               end
            end
            if (sweep_done) begin
               wr        = '{en: 1'b1, addr: rank_i_ff[IDX_W-1:0],
                             data: DATA_W'(rank_cnt_ff)};
               rank_i_in = CNT_W'(rank_i_ff + CNT_W'(1));
               if (CNT_W'(rank_i_ff + CNT_W'(1)) == count_ff) begin
                  bank_in     = !bank_ff;
                  scan_in     = '0;
                  unsorted_in = 1'b0;
                  state_in    = ST_CHECK;
               end else begin
                  state_in = ST_RK_GET;
               end
            end
         end

         // Order check: any descent marks the list unsorted.
         ST_CHECK: begin
            if (pv_ff) begin
               if ((pidx_ff != '0) && ($signed(prev_ff) > $signed(rd_data))) begin
                  unsorted_in = 1'b1;
               end
               prev_in = rd_data;
            end
            if (sweep_done) begin
               scan_in = '0;
               wcnt_in = '0;
               if (!unsorted_ff || (pass_ff == PASS_W'(rtbrs_pkg::PASS_LIMIT))) begin
                  state_in = ST_EM_RD;
               end else begin
                  state_in = ST_PASS_Z;
               end
            end
         end

         // First walk: elements with the bit clear go to the other bank in order.
         ST_PASS_Z: begin
            if (pv_ff && !rd_data[bit_idx]) begin
               wr      = '{en: 1'b1, addr: wcnt_ff[IDX_W-1:0], data: rd_data};
               wcnt_in = CNT_W'(wcnt_ff + CNT_W'(1));
            end
            if (sweep_done) begin
               zcnt_in  = wcnt_ff;
               scan_in  = '0;
               state_in = ST_PASS_O;
            end
         end

         // Second walk: elements with the bit set follow them.
         ST_PASS_O: begin
            if (pv_ff && rd_data[bit_idx]) begin
               wr      = '{en: 1'b1, addr: wcnt_ff[IDX_W-1:0], data: rd_data};
               wcnt_in = CNT_W'(wcnt_ff + CNT_W'(1));
            end
            if (sweep_done) begin
               if (moves_sum > (MOVE_W + 1)'(rtbrs_pkg::MOVE_CAP)) begin
                  moves_in = MOVE_W'(rtbrs_pkg::MOVE_CAP);
               end else begin
                  moves_in = moves_sum[MOVE_W-1:0];
               end
               pass_in     = PASS_W'(pass_ff + PASS_W'(1));
               bank_in     = !bank_ff;
               scan_in     = '0;
               unsorted_in = 1'b0;
               state_in    = ST_CHECK;
            end
         end

         ST_EM_RD: begin
            state_in = ST_EM_LD;
         end

         ST_EM_LD: begin
            out_value_in = rd_data;
            out_moves_in = moves_ff;
            out_last_in  = (CNT_W'(scan_ff + CNT_W'(1)) == count_ff);
            rsp_valid_in = 1'b1;
            state_in     = ST_EM_WAIT;
         end

         // Hold the beat until taken, then fetch the next or start over.
         ST_EM_WAIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (out_last_ff) begin
                  count_in = '0;
                  neg_in   = 1'b0;
                  pass_in  = '0;
                  moves_in = '0;
                  scan_in  = '0;
                  state_in = ST_LOAD;
               end else begin
                  scan_in  = CNT_W'(scan_ff + CNT_W'(1));
                  state_in = ST_EM_RD;
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         neg_ff       <= 1'b0;
         bank_ff      <= 1'b0;
         pass_ff      <= '0;
         moves_ff     <= '0;
         scan_ff      <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         neg_ff       <= neg_in;
         bank_ff      <= bank_in;
         pass_ff      <= pass_in;
         moves_ff     <= moves_in;
         scan_ff      <= scan_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pidx_ff      <= pidx_in;
      rank_i_ff    <= rank_i_in;
      rank_cnt_ff  <= rank_cnt_in;
      vi_ff        <= vi_in;
      prev_ff      <= prev_in;
      unsorted_ff  <= unsorted_in;
      wcnt_ff      <= wcnt_in;
      zcnt_ff      <= zcnt_in;
      out_value_ff <= out_value_in;
      out_moves_ff <= out_moves_in;
      out_last_ff  <= out_last_in;
   end

   // Response channel.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{rtbrs_pkg::RSP_PAD_W{1'b0}}, out_moves_ff, out_value_ff};
   assign rsp_tlast  = out_last_ff;

   // Checks on the sequencer.
   `RTBRS_ASSERT_SAME(a_load_excl_emit, clock, reset, req_tready, !rsp_tvalid, "load overlaps emit")
   `RTBRS_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(rtbrs_pkg::MAX_ITEMS), "list count overflow")
   `RTBRS_ASSERT_SAME(a_pass_bound, clock, reset, (state_ff == ST_PASS_Z) || (state_ff == ST_PASS_O), pass_ff < PASS_W'(rtbrs_pkg::PASS_LIMIT), "radix pass beyond limit")
   `RTBRS_ASSERT_NEXT(a_last_reloads, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, req_tready && (count_ff == '0), "no return to load after last beat")

endmodule

// ----- hdl/rtbrs_ram.sv -----
// ----------------------------------------------------------------------------
// rtbrs_ram
// One list bank: single write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtbrs_ram (
   input  logic                              clock,
   input  rtbrs_pkg::ram_wr_type             wr,
   input  logic [rtbrs_pkg::IDX_W-1:0]       rd_addr,
   output logic [rtbrs_pkg::DATA_W-1:0]      rd_data
);

   logic [rtbrs_pkg::DATA_W-1:0] mem [rtbrs_pkg::MAX_ITEMS];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- dv/rank_then_binary_radix_sort_tb.sv -----
// ----------------------------------------------------------------------------
// rank_then_binary_radix_sort_tb
// Streams lists of signed words into the sorter and checks every sorted beat,
// with its move count and end marker, against a built-in software sorter.
// Both stream sides stall at random, with a calm stretch and full drains before some lists.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rank_then_binary_radix_sort_tb;

   // Sizes of the block under test.
   localparam int DATA_W      = rtbrs_pkg::DATA_W;
   localparam int MOVE_W      = rtbrs_pkg::MOVE_W;
   localparam int MAX_ITEMS   = rtbrs_pkg::MAX_ITEMS;
   localparam int PASS_LIMIT  = rtbrs_pkg::PASS_LIMIT;
   localparam int MOVE_CAP    = rtbrs_pkg::MOVE_CAP;
   localparam int REQ_TDATA_W = rtbrs_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W = rtbrs_pkg::RSP_TDATA_W;
   localparam int RSP_FIELD_W = rtbrs_pkg::RSP_FIELD_W;

   localparam int RUN_LIMIT   = 1_000_000;
   localparam int DRAIN_WAIT  = 200;
   localparam int IDLE_PCT    = 35;
   localparam int REPORT_MAX  = 10;
   localparam int ITEM_TARGET = 500;

   // Value styles used by the random lists.
   typedef enum int {
      VAL_FULL,
      VAL_POSITIVE,
      VAL_TIES,
      VAL_SMALL_SIGNED
   } value_style_type;

   typedef struct {
      logic [DATA_W-1:0] value;
      logic              last;
      bit                hold;   // wait for every sorted beat before sending
   } list_beat_type;

   typedef struct {
      logic [DATA_W-1:0] value;
      logic [MOVE_W-1:0] moves;
      logic              last;
   } sorted_beat_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;

   list_beat_type   pending_beats[$];
   sorted_beat_type sorted_expect[$];

   // Shadow copy of the list being collected.
   logic [DATA_W-1:0] shadow_list[MAX_ITEMS];
   int                shadow_len = 0;

   int sent_count     = 0;
   int got_count      = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   rank_then_binary_radix_sort dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // True when each shadow element is at most the next, compared as signed.
   function automatic bit shadow_ascending();
      for (int i = 1; i < shadow_len; i++)
         if ($signed(shadow_list[i-1]) > $signed(shadow_list[i]))
            return 1'b0;
      return 1'b1;
   endfunction

   // Collects one accepted beat; on the list end, ranks and radix sorts the
   // shadow list and queues the sorted beats that the block should return.
   task automatic collect_and_sort(input logic [DATA_W-1:0] value, input logic last);
      logic [DATA_W-1:0] ranks[MAX_ITEMS];
      logic [DATA_W-1:0] zero_side[MAX_ITEMS];
      logic [DATA_W-1:0] one_side[MAX_ITEMS];
      int                n_zero;
      int                n_one;
      int                rank;
      int                bit_idx;
      int                moves;
      bit                has_negative;
      sorted_beat_type   beat;
      if (shadow_len < MAX_ITEMS) begin
         shadow_list[shadow_len] = value;
         shadow_len++;
      end
      if (!last)
         return;

      // Ranking happens only when some element is negative; ties rank in
      // list order.
      has_negative = 1'b0;
      for (int i = 0; i < shadow_len; i++)
         if (shadow_list[i][DATA_W-1])
            has_negative = 1'b1;
      if (has_negative) begin
         for (int i = 0; i < shadow_len; i++) begin
            rank = 0;
            for (int j = 0; j < shadow_len; j++)
               if ($signed(shadow_list[j]) < $signed(shadow_list[i]) ||
                   (shadow_list[j] == shadow_list[i] && j < i))
                  rank++;
            ranks[i] = rank;
         end
         for (int i = 0; i < shadow_len; i++)
            shadow_list[i] = ranks[i];
      end

      // Stable binary partitions from bit 0 up, until in order or out of passes.
      moves   = 0;
      bit_idx = 0;
      while (!shadow_ascending() && bit_idx < PASS_LIMIT) begin
         n_zero = 0;
         n_one  = 0;
         for (int i = 0; i < shadow_len; i++) begin
            if (shadow_list[i][bit_idx] == 1'b0) begin
               zero_side[n_zero] = shadow_list[i];
               n_zero++;
            end else begin
               one_side[n_one] = shadow_list[i];
               n_one++;
            end
         end
         moves += shadow_len + n_zero;
         if (moves > MOVE_CAP)
            moves = MOVE_CAP;
         for (int i = 0; i < n_zero; i++)
            shadow_list[i] = zero_side[i];
         for (int i = 0; i < n_one; i++)
            shadow_list[n_zero + i] = one_side[i];
         bit_idx++;
      end

      for (int i = 0; i < shadow_len; i++) begin
         beat.value = shadow_list[i];
         beat.moves = moves[MOVE_W-1:0];
         beat.last  = (i == shadow_len - 1);
         sorted_expect.push_back(beat);
      end
      shadow_len = 0;
   endtask

   task automatic queue_beat(input logic [DATA_W-1:0] value, input logic last, input bit hold);
      list_beat_type beat;
      beat.value = value;
      beat.last  = last;
      beat.hold  = hold;
      pending_beats.push_back(beat);
   endtask

   function automatic logic [DATA_W-1:0] pick_value(input value_style_type style);
      logic [DATA_W-1:0] v;
      case (style)
         VAL_FULL:         v = $urandom;
         VAL_POSITIVE:     v = $urandom & 32'h7FFF_FFFF;
         VAL_TIES:         v = $urandom_range(0, 15);
         default:          v = $urandom_range(0, 15) - 8;
      endcase
      return v;
   endfunction

   task automatic queue_random_list(input int len, input bit hold);
      value_style_type style;
      style = value_style_type'($urandom_range(0, 3));
      for (int i = 0; i < len; i++)
         queue_beat(pick_value(style), i == len - 1, hold && i == 0);
   endtask

   // Stimulus: directed lists first, then random lists of mixed sizes.
   initial begin : stimulus
      int len;
      int pick;
      // Single largest positive value, then single smallest negative value.
      queue_beat(32'h7FFF_FFFF, 1'b1, 1'b0);
      queue_beat(32'h8000_0000, 1'b1, 1'b0);
      // Small unsorted positive list.
      queue_beat(32'd3, 1'b0, 1'b0);
      queue_beat(32'd1, 1'b0, 1'b0);
      queue_beat(32'd2, 1'b1, 1'b0);
      // Already ascending list: no pass, no moves.
      queue_beat(32'd1, 1'b0, 1'b0);
      queue_beat(32'd2, 1'b0, 1'b0);
      queue_beat(32'd3, 1'b0, 1'b0);
      queue_beat(32'd4, 1'b1, 1'b0);
      // Equal values with negatives present: ties ranked in list order.
      queue_beat(32'd5, 1'b0, 1'b0);
      queue_beat(32'hFFFF_FFFF, 1'b0, 1'b0);
      queue_beat(32'd5, 1'b0, 1'b0);
      queue_beat(32'hFFFF_FFFF, 1'b0, 1'b0);
      queue_beat(32'd0, 1'b1, 1'b0);
      // Extremes mixed together.
      queue_beat(32'h7FFF_FFFF, 1'b0, 1'b0);
      queue_beat(32'h8000_0000, 1'b0, 1'b0);
      queue_beat(32'd0, 1'b0, 1'b0);
      queue_beat(32'hFFFF_FFFF, 1'b0, 1'b0);
      queue_beat(32'd1, 1'b1, 1'b0);
      // Descending positive list with high bits set.
      queue_beat(32'h4000_0000, 1'b0, 1'b0);
      queue_beat(32'h2000_0000, 1'b0, 1'b0);
      queue_beat(32'h0000_0002, 1'b0, 1'b0);
      queue_beat(32'h0000_0001, 1'b1, 1'b0);

      // A full list and an overflowing list whose excess values are dropped.
      queue_random_list(MAX_ITEMS, 1'b1);
      queue_random_list(MAX_ITEMS + 3, 1'b0);
      while (pending_beats.size() < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 75)
            len = $urandom_range(1, 12);
         else if (pick < 93)
            len = $urandom_range(13, 40);
         else if (pick < 97)
            len = $urandom_range(41, MAX_ITEMS);
         else
            len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
         queue_random_list(len, $urandom_range(0, 7) == 0);
      end
   end

   // Reset once at the start.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Request driver: feeds list beats with random gaps and holds valid beats
   // until taken.
   always @(posedge clock) begin : req_driver
      list_beat_type nxt;
      bit            gap;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            collect_and_sort(req_tdata[DATA_W-1:0], req_tlast);
            sent_count++;
         end
         if (!req_tvalid || req_tready) begin
            gap = (sent_count < 200 || sent_count >= 300) &&
                  ($urandom_range(0, 99) < IDLE_PCT);
            if (pending_beats.size() > 0 && !gap &&
                (!pending_beats[0].hold || sorted_expect.size() == 0)) begin
               nxt = pending_beats.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.value;
               req_tlast  <= nxt.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: random back-pressure and a field-by-field check of
   // each sorted beat.
   always @(posedge clock) begin : rsp_monitor
      sorted_beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_count++;
            if (sorted_expect.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("unexpected sorted beat: data %h last %b", rsp_tdata, rsp_tlast);
            end else begin
               want = sorted_expect.pop_front();
               if (rsp_tdata[DATA_W-1:0] !== want.value ||
                   rsp_tdata[DATA_W+MOVE_W-1:DATA_W] !== want.moves ||
                   rsp_tdata[RSP_TDATA_W-1:RSP_FIELD_W] !== '0 ||
                   rsp_tlast !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display("sorted beat %0d: expected value %h moves %0d last %b, got value %h moves %0d pad %b last %b",
                              got_count, want.value, want.moves, want.last,
                              rsp_tdata[DATA_W-1:0], rsp_tdata[DATA_W+MOVE_W-1:DATA_W],
                              rsp_tdata[RSP_TDATA_W-1:RSP_FIELD_W], rsp_tlast);
               end
            end
         end
         rsp_tready <= !((got_count < 200 || got_count >= 320) &&
                         ($urandom_range(0, 99) < IDLE_PCT));
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // End of run: all beats sent, all sorted beats back, then a quiet period.
   initial begin : finish_run
      @(negedge reset);
      wait (pending_beats.size() == 0 && !req_tvalid);
      wait (sorted_expect.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sorted_expect.size() != 0)
         $display("%0d sorted beats never arrived", sorted_expect.size());
      if (mismatch_count == 0 && sorted_expect.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- rank_then_binary_radix_sort.f -----
+incdir+hdl
hdl/rtbrs_pkg.sv
hdl/rtbrs_ram.sv
hdl/rank_then_binary_radix_sort.sv
dv/rank_then_binary_radix_sort_tb.sv
